// ===== src/lad_pkg.sv =====
// ----------------------------------------------------------------------------
// Ladder filter package
// Shared widths, coefficient constants, job record and rounding helper.
// ----------------------------------------------------------------------------
package lad_pkg;

   localparam int SAMPLE_W  = 24;
   localparam int FRAC_BITS = 18;
   localparam int CQ        = 28;
   localparam int ISR_W     = 20;
   localparam int FC_W      = 16;
   localparam int RES_W     = 16;
   localparam int OUT_W     = 22;

   localparam int COEF_W  = CQ;
   localparam int K_W     = CQ + 2;
   localparam int T_W     = CQ + 1;
   localparam int RATIO_W = 30;
   localparam int R_W     = 31;

   localparam int DIV_N_W = 64;
   localparam int DIV_D_W = 35;
   localparam int DIV_Q_W = 30;

   localparam logic [ISR_W-1:0]  ISR_RESET = 20'd89478;
   localparam logic [T_W-1:0]    C_1P8     = 29'd483183821;
   localparam logic [COEF_W-1:0] C_0P8     = 28'd214748365;
   localparam logic [T_W-1:0]    C_TSCALE  = 29'd372118382;
   localparam logic [COEF_W-1:0] F_HI      = 28'd263066747;
   localparam logic [COEF_W-1:0] F_LO      = 28'd134218;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] smp;
      logic [COEF_W-1:0]          p;
      logic signed [K_W-1:0]      k;
      logic [R_W-1:0]             r;
   } lad_job_type;

   // Unsigned shift right, rounding half up.
   function automatic logic [63:0] rnd_shr(input logic [63:0] v, input int unsigned s);
      logic [63:0] half;
      half = 64'd1 << (s - 1);
      return (v + half) >> s;
   endfunction

endpackage

// ===== src/lad_div.sv =====
// ----------------------------------------------------------------------------
// Ladder filter divider
// Restoring divider, one quotient bit per cycle, quotient known to fit.
// ----------------------------------------------------------------------------
module lad_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [lad_pkg::DIV_N_W-1:0]   dividend,
   input  logic [lad_pkg::DIV_D_W-1:0]   divisor,
   output logic                          done,
   output logic [lad_pkg::DIV_Q_W-1:0]   quotient
);
   import lad_pkg::*;

   logic [DIV_D_W-1:0] rem_ff, rem_in;
   logic [DIV_Q_W-1:0] sh_ff, sh_in;
   logic [DIV_D_W-1:0] dsr_ff;
   logic [4:0]         cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DIV_D_W:0]   trial;

   always_comb begin
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, sh_ff[DIV_Q_W-1]};
      if (start) begin
         rem_in  = DIV_D_W'(dividend[DIV_N_W-1:DIV_Q_W]);
         sh_in   = dividend[DIV_Q_W-1:0];
         cnt_in  = 5'(DIV_Q_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in the next dividend bit, collect the quotient bit at the bottom
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = DIV_D_W'(trial - {1'b0, dsr_ff});
            sh_in  = {sh_ff[DIV_Q_W-2:0], 1'b1};
         end else begin
            rem_in = DIV_D_W'(trial);
            sh_in  = {sh_ff[DIV_Q_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      cnt_ff <= cnt_in;
      if (start) dsr_ff <= divisor;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = sh_ff;

endmodule

// ===== src/lad_coef.sv =====
// ----------------------------------------------------------------------------
// Ladder filter front end
// Accepts samples, derives cutoff, pole and resonance coefficients.
// ----------------------------------------------------------------------------
module lad_coef (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [lad_pkg::SAMPLE_W-1:0] req_sample_in,
   input  logic [lad_pkg::FC_W-1:0]        req_cutoff_hz,
   input  logic [lad_pkg::RES_W-1:0]       req_resonance,
   input  logic                            csr_wr_en,
   input  logic [lad_pkg::ISR_W-1:0]       csr_wr_data,
   output logic                            job_push,
   output lad_pkg::lad_job_type            job_data,
   input  logic                            job_full
);
   import lad_pkg::*;

   typedef enum logic [3:0] {
      F_IDLE, F_MFC, F_GF, F_MA, F_GA, F_MP, F_GP, F_MT, F_GT,
      F_MTT, F_GTT, F_DGO, F_DWAIT, F_MR, F_GR, F_PUSH
   } fstate_type;

   fstate_type          state_ff;
   logic [ISR_W-1:0]    isr_ff;
   logic signed [SAMPLE_W-1:0] smp_ff;
   logic [FC_W-1:0]     fc_ff;
   logic [RES_W-1:0]    res_ff;
   logic [COEF_W-1:0]   f_ff, p_ff;
   logic [T_W-1:0]      ca_ff, t_ff;
   logic [33:0]         num_ff, den_ff;
   logic [RATIO_W-1:0]  ratio_ff;
   logic [R_W-1:0]      r_ff;
   logic [63:0]         prod_ff;
   logic [31:0]         mul_a, mul_b;
   logic [36:0]         f_raw;
   logic [33:0]         t2, sx;
   logic                div_start, div_done;
   logic [DIV_Q_W-1:0]  div_q;
   logic [DIV_N_W-1:0]  div_n;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         F_MFC:   begin mul_a = 32'(fc_ff);  mul_b = 32'(isr_ff);   end
         F_MA:    begin mul_a = 32'(C_0P8);  mul_b = 32'(f_ff);     end
         F_MP:    begin mul_a = 32'(f_ff);   mul_b = 32'(ca_ff);    end
         F_MT:    begin
            mul_a = 32'((T_W'(1) << CQ) - {1'b0, p_ff});
            mul_b = 32'(C_TSCALE);
         end
         F_MTT:   begin mul_a = 32'(t_ff);   mul_b = 32'(t_ff);     end
         F_MR:    begin mul_a = 32'(res_ff); mul_b = 32'(ratio_ff); end
         default: begin mul_a = '0;          mul_b = '0;            end
      endcase
   end

   // 2*fc*isr with four fraction bits dropped, rounded half up
   assign f_raw = 37'(prod_ff[35:0]) + 37'd4;
   assign t2    = 34'(12) * (34'd1 << CQ) + 34'(rnd_shr(prod_ff, CQ));
   assign sx    = 34'(t_ff) * 34'd6;

   assign div_start = (state_ff == F_DGO);
   assign div_n     = {4'b0, num_ff, 26'b0} + 64'(den_ff >> 1);

   lad_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_n),
      .divisor  (DIV_D_W'(den_ff)),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (reset) begin
         state_ff <= F_IDLE;
         isr_ff   <= ISR_RESET;
      end else begin
         if (csr_wr_en) isr_ff <= csr_wr_data;
         case (state_ff)
            F_IDLE: begin
               if (req_valid) begin
                  smp_ff   <= req_sample_in;
                  fc_ff    <= req_cutoff_hz;
                  res_ff   <= req_resonance;
                  state_ff <= F_MFC;
               end
            end
            F_MFC: state_ff <= F_GF;
            F_GF: begin
               if ((f_raw >> 3) > 37'(F_HI))      f_ff <= F_HI;
               else if ((f_raw >> 3) < 37'(F_LO)) f_ff <= F_LO;
               else                               f_ff <= COEF_W'(f_raw >> 3);
               state_ff <= F_MA;
            end
            F_MA: state_ff <= F_GA;
            F_GA: begin
               ca_ff    <= C_1P8 - T_W'(rnd_shr(prod_ff, CQ));
               state_ff <= F_MP;
            end
            F_MP: state_ff <= F_GP;
            F_GP: begin
               p_ff     <= COEF_W'(rnd_shr(prod_ff, CQ));
               state_ff <= F_MT;
            end
            F_MT: state_ff <= F_GT;
            F_GT: begin
               t_ff     <= T_W'(rnd_shr(prod_ff, CQ));
               state_ff <= F_MTT;
            end
            F_MTT: state_ff <= F_GTT;
            F_GTT: begin
               num_ff   <= t2 + sx;
               den_ff   <= (t2 > sx) ? t2 - sx : 34'd1;
               state_ff <= F_DGO;
            end
            F_DGO: state_ff <= F_DWAIT;
            F_DWAIT: begin
               if (div_done) begin
                  ratio_ff <= div_q;
                  state_ff <= F_MR;
               end
            end
            F_MR: state_ff <= F_GR;
            F_GR: begin
               r_ff     <= R_W'(rnd_shr(prod_ff, 14));
               state_ff <= F_PUSH;
            end
            F_PUSH: begin
               if (!job_full) state_ff <= F_IDLE;
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

   assign req_ready    = (state_ff == F_IDLE);
   assign job_push     = (state_ff == F_PUSH) && !job_full;
   assign job_data.smp = smp_ff;
   assign job_data.p   = p_ff;
   assign job_data.k   = $signed({1'b0, p_ff, 1'b0}) - $signed(K_W'(1) << CQ);
   assign job_data.r   = r_ff;

endmodule

// ===== src/lad_queue.sv =====
// ----------------------------------------------------------------------------
// Ladder filter job queue
// Two-entry queue between coefficient front end and ladder back end.
// ----------------------------------------------------------------------------
module lad_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  lad_pkg::lad_job_type push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output lad_pkg::lad_job_type pop_data
);
   import lad_pkg::*;

   lad_job_type mem_ff [2];
   logic        wr_ff, rd_ff;
   logic [1:0]  cnt_ff;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop)  rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign pop_data  = mem_ff[rd_ff];

endmodule

// ===== src/lad_ladder.sv =====
// ----------------------------------------------------------------------------
// Ladder filter back end
// Feedback, four one-pole sections on a shared multiplier, soft clip.
// ----------------------------------------------------------------------------
module lad_ladder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_valid,
   input  lad_pkg::lad_job_type          job_data,
   output logic                          job_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [lad_pkg::OUT_W-1:0] rsp_sample_out
);
   import lad_pkg::*;

   typedef enum logic [3:0] {
      B_IDLE, B_XM, B_XG, B_PM1, B_PM2, B_PG, B_SQM, B_SQG, B_NM, B_NG, B_DW, B_OUT
   } bstate_type;

   localparam logic signed [47:0] SMP_MAX = 48'((64'sd1 <<< (SAMPLE_W - 1)) - 1);
   localparam logic signed [47:0] SMP_MIN = -48'(64'sd1 <<< (SAMPLE_W - 1));
   localparam logic [32:0] H_MAX = 33'(3) * (33'd1 << CQ);
   localparam logic signed [22:0] LIM = 23'sd4 <<< FRAC_BITS;

   bstate_type                 state_ff;
   lad_job_type                job_ff;
   logic signed [SAMPLE_W-1:0] s_ff [4];
   logic signed [SAMPLE_W-1:0] pv_ff [4];
   logic [1:0]                 idx_ff;
   logic signed [SAMPLE_W-1:0] u_ff, y4_ff;
   logic signed [66:0]         prod_ff, acc_ff;
   logic signed [31:0]         mul_a;
   logic signed [34:0]         mul_b;
   logic [29:0]                h_ff, h_c;
   logic [33:0]                c_ff;
   logic [34:0]                den_ff;
   logic                       neg_ff;
   logic signed [OUT_W-1:0]    out_ff;
   logic                       out_valid_ff;
   logic [SAMPLE_W-1:0]        mag;
   logic [32:0]                hw;
   logic [31:0]                sq;
   logic signed [24:0]         usum;
   logic signed [SAMPLE_W-1:0] x_c, yn_c;
   logic [21:0]                rr;
   logic signed [22:0]         ys, yc;
   logic                       div_start, div_done;
   logic [DIV_Q_W-1:0]         div_q;
   logic [DIV_N_W-1:0]         div_n;

   // Signed shift right, rounding half away from zero.
   function automatic logic signed [47:0] srsh(input logic signed [66:0] v,
                                               input int unsigned s);
      logic signed [66:0] b;
      b = v + (67'sd1 <<< (s - 1)) - (v[66] ? 67'sd1 : 67'sd0);
      return 48'(b >>> s);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sat_smp(input logic signed [47:0] v);
      if (v > SMP_MAX) return SAMPLE_W'(SMP_MAX);
      if (v < SMP_MIN) return SAMPLE_W'(SMP_MIN);
      return SAMPLE_W'(v);
   endfunction

   assign mag  = y4_ff[SAMPLE_W-1] ? SAMPLE_W'(-y4_ff) : SAMPLE_W'(y4_ff);
   assign hw   = 33'(mag) << (CQ - FRAC_BITS - 1);
   assign h_c  = (hw > H_MAX) ? 30'(H_MAX) : hw[29:0];
   assign usum = 25'(u_ff) + 25'(pv_ff[idx_ff]);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         B_XM:    begin mul_a = $signed({1'b0, job_ff.r});    mul_b = 35'(s_ff[3]);       end
         B_PM1:   begin mul_a = 32'(usum);                    mul_b = $signed({7'b0, job_ff.p}); end
         B_PM2:   begin mul_a = 32'(job_ff.k);                mul_b = 35'(s_ff[idx_ff]);  end
         B_SQM:   begin mul_a = $signed({2'b0, h_c});         mul_b = $signed({5'b0, h_c}); end
         B_NM:    begin mul_a = $signed({2'b0, h_ff});        mul_b = $signed({1'b0, c_ff}); end
         default: begin mul_a = '0;                           mul_b = '0;                 end
      endcase
   end

   assign x_c  = sat_smp(48'(job_ff.smp) - srsh(prod_ff, 26));
   assign yn_c = sat_smp(srsh(acc_ff - prod_ff, CQ));
   assign sq   = 32'(rnd_shr(64'(prod_ff), CQ));
   assign div_start = (state_ff == B_NG);
   assign div_n     = 64'(prod_ff) + 64'(den_ff >> 1);

   // soft clip result back to the sample format, sign restored, clamped to +/-4
   assign rr = 22'((31'(div_q) + 31'd256) >> (CQ - FRAC_BITS - 1));
   assign ys = neg_ff ? -$signed({1'b0, rr}) : $signed({1'b0, rr});
   assign yc = (ys > LIM) ? LIM : ((ys < -LIM) ? -LIM : ys);

   lad_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_n),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
         for (int i = 0; i < 4; i++) begin
            s_ff[i]  <= '0;
            pv_ff[i] <= '0;
         end
      end else begin
         if (out_valid_ff && rsp_ready && state_ff != B_OUT) out_valid_ff <= 1'b0;
         case (state_ff)
            B_IDLE: begin
               if (job_valid) begin
                  job_ff   <= job_data;
                  state_ff <= B_XM;
               end
            end
            B_XM: state_ff <= B_XG;
            B_XG: begin
               u_ff     <= x_c;
               idx_ff   <= 2'd0;
               state_ff <= B_PM1;
            end
            B_PM1: state_ff <= B_PM2;
            B_PM2: begin
               acc_ff   <= prod_ff;
               state_ff <= B_PG;
            end
            B_PG: begin
               pv_ff[idx_ff] <= u_ff;
               if (idx_ff == 2'd3) begin
                  y4_ff    <= yn_c;
                  state_ff <= B_SQM;
               end else begin
                  s_ff[idx_ff] <= yn_c;
                  u_ff         <= yn_c;
                  idx_ff       <= idx_ff + 2'd1;
                  state_ff     <= B_PM1;
               end
            end
            B_SQM: begin
               h_ff     <= h_c;
               neg_ff   <= y4_ff[SAMPLE_W-1];
               state_ff <= B_SQG;
            end
            B_SQG: begin
               c_ff     <= 34'(27) * (34'd1 << CQ) + 34'(sq);
               den_ff   <= 35'(27) * (35'd1 << CQ) + 35'(9) * 35'(sq);
               state_ff <= B_NM;
            end
            B_NM: state_ff <= B_NG;
            B_NG: state_ff <= B_DW;
            B_DW: begin
               if (div_done) begin
                  s_ff[3]  <= SAMPLE_W'(yc);
                  state_ff <= B_OUT;
               end
            end
            B_OUT: begin
               // hold until the output register is free
               if (!out_valid_ff || rsp_ready) begin
                  out_ff       <= OUT_W'(s_ff[3]);
                  out_valid_ff <= 1'b1;
                  state_ff     <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   assign job_pop        = (state_ff == B_IDLE) && job_valid;
   assign rsp_valid      = out_valid_ff;
   assign rsp_sample_out = out_ff;

endmodule

// ===== src/four_pole_ladder_filter_core.sv =====
// ----------------------------------------------------------------------------
// Four-pole ladder filter core
// Resonant four-pole lowpass with soft-clipped feedback, Q5.18 samples.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one sample with its cutoff (Hz) and resonance (Q2.14); a
//   transaction completes when req_valid and req_ready are both high.
//   rsp_* returns one filtered sample per input transaction, in order.
//   csr_wr_en/csr_wr_data write the inverse sample rate; write only while idle.
// Structure:
//   The front end works through its coefficient steps for each sample,
//   including the wait on a bit-serial divider. The back end spends each
//   sample on eleven products on one shared multiplier plus the soft-clip
//   division. The back end sets the throughput and takes a new sample only
//   once the last one has left it.
//   A two-entry queue between the two halves lets coefficient work for later
//   samples run ahead of the ladder.
// Reset:
//   Synchronous; clears filter state and queue, loads the default rate.
// Stall:
//   The result register holds while rsp_ready is low; the back end then
//   waits, the queue fills and req_ready drops.
// ----------------------------------------------------------------------------
module four_pole_ladder_filter_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [lad_pkg::SAMPLE_W-1:0] req_sample_in,
   input  logic [lad_pkg::FC_W-1:0]           req_cutoff_hz,
   input  logic [lad_pkg::RES_W-1:0]          req_resonance,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [lad_pkg::OUT_W-1:0]   rsp_sample_out,
   input  logic                               csr_wr_en,
   input  logic [lad_pkg::ISR_W-1:0]          csr_wr_data
);
   import lad_pkg::*;

   lad_job_type push_data, pop_data;
   logic        push, full, pop, not_empty;

   lad_coef u_coef (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample_in (req_sample_in),
      .req_cutoff_hz (req_cutoff_hz),
      .req_resonance (req_resonance),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .job_push      (push),
      .job_data      (push_data),
      .job_full      (full)
   );

   lad_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_data  (pop_data)
   );

   lad_ladder u_ladder (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (not_empty),
      .job_data       (pop_data),
      .job_pop        (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out)
   );

endmodule

// ===== src/lad_checker.sv =====
// ----------------------------------------------------------------------------
// Ladder filter port checker
// Port-level checks on reset, outstanding results, stall hold and output range.
// ----------------------------------------------------------------------------
module lad_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [lad_pkg::OUT_W-1:0]    rsp_sample_out
);
   import lad_pkg::*;

   logic [3:0] pend_ff;

   // track transactions accepted but not yet returned
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 4'd0;
      end else begin
         pend_ff <= pend_ff + 4'(req_valid && req_ready) - 4'(rsp_valid && rsp_ready);
      end
   end

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid && req_ready)
      else $error("outputs not idle after reset");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 4'd0)
      else $error("result without an outstanding transaction");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out))
      else $error("stalled result changed");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sample_out <= (22'sd1 <<< 20) && rsp_sample_out >= -(22'sd1 <<< 20))
      else $error("output beyond clamp");

endmodule

bind four_pole_ladder_filter_core lad_checker u_lad_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_sample_out (rsp_sample_out)
);

// ===== bench/four_pole_ladder_filter_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Four-pole ladder filter core testbench
// Feeds samples with cutoff and resonance through a bursty valid/ready driver,
// predicts each filtered sample with a bit-exact model of the ladder, and
// compares every output transaction in order. Covers several rate settings.
// ----------------------------------------------------------------------------
module four_pole_ladder_filter_core_tb;
   import lad_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 200;
   localparam int N_RANDOM       = 1600;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] smp;
      logic [FC_W-1:0]            fc;
      logic [RES_W-1:0]           res;
   } sample_txn_type;

   // Marks a point where the driver waits for all outputs to arrive and may
   // retune the rate register before continuing.
   typedef struct {
      bit          is_retune;
      bit          do_write;
      logic [ISR_W-1:0] isr;
      sample_txn_type txn;
   } drive_entry_type;

   logic clock;
   logic reset;
   logic req_valid, req_ready;
   logic signed [SAMPLE_W-1:0] req_sample_in;
   logic [FC_W-1:0]  req_cutoff_hz;
   logic [RES_W-1:0] req_resonance;
   logic rsp_valid, rsp_ready;
   logic signed [OUT_W-1:0] rsp_sample_out;
   logic csr_wr_en;
   logic [ISR_W-1:0] csr_wr_data;

   four_pole_ladder_filter_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_sample_in(req_sample_in), .req_cutoff_hz(req_cutoff_hz),
      .req_resonance(req_resonance),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_sample_out(rsp_sample_out),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // Ladder model state.
   logic [ISR_W-1:0] mdl_isr;
   longint s1, s2, s3, s4, u1, u2, u3, u4;

   drive_entry_type        pending_q[$];
   logic signed [OUT_W-1:0] filtered_q[$];
   int  mismatches, n_sent, n_checked, n_writes, idle_cycles;
   bit  stim_done;

   function automatic longint rnd_u(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint rnd_s(longint v, int s);
      longint m;
      m = (v < 0) ? -v : v;
      m = rnd_u(m, s);
      return (v < 0) ? -m : m;
   endfunction

   function automatic longint clamp_sample(longint v);
      longint hi, lo;
      hi = (longint'(1) << (SAMPLE_W - 1)) - 1;
      lo = -(longint'(1) << (SAMPLE_W - 1));
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   function automatic longint one_pole(longint u, longint up, longint y, longint p, longint k);
      return clamp_sample(rnd_s((u + up) * p - k * y, CQ));
   endfunction

   function automatic longint soft_sat(longint y);
      longint m, h, sq, num, den, q, r, one;
      one = longint'(1) << CQ;
      m = (y < 0) ? -y : y;
      h = (m << (CQ - FRAC_BITS)) >> 1;
      if (h > 3 * one) h = 3 * one;
      sq  = rnd_u(h * h, CQ);
      num = h * (27 * one + sq);
      den = 27 * one + 9 * sq;
      q   = (num + den / 2) / den;
      r   = rnd_u(2 * q, CQ - FRAC_BITS);
      return (y < 0) ? -r : r;
   endfunction

   // Advance the ladder by one sample and return the filtered output.
   function automatic logic signed [OUT_W-1:0] ladder_step(sample_txn_type t);
      longint one, f, a, p, k, tt, t2, sx, num, den, ratio, r, x, y, lim;
      one = longint'(1) << CQ;
      f = (2 * longint'(t.fc) * longint'(mdl_isr) + 8) >> 4;
      if (f > longint'(F_HI)) f = F_HI;
      if (f < longint'(F_LO)) f = F_LO;
      a  = rnd_u(longint'(C_0P8) * f, CQ);
      p  = rnd_u(f * (longint'(C_1P8) - a), CQ);
      k  = 2 * p - one;
      tt = rnd_u((one - p) * longint'(C_TSCALE), CQ);
      t2 = 12 * one + rnd_u(tt * tt, CQ);
      sx = 6 * tt;
      num = t2 + sx;
      den = (t2 > sx) ? t2 - sx : 1;
      ratio = ((num << 26) + den / 2) / den;
      r = rnd_u(longint'(t.res) * ratio, 14);
      x = clamp_sample(longint'(t.smp) - rnd_s(r * s4, 26));
      s1 = one_pole(x, u1, s1, p, k);  u1 = x;
      s2 = one_pole(s1, u2, s2, p, k); u2 = s1;
      s3 = one_pole(s2, u3, s3, p, k); u3 = s2;
      y  = one_pole(s3, u4, s4, p, k); u4 = s3;
      y = soft_sat(y);
      lim = longint'(4) << FRAC_BITS;
      if (y > lim) y = lim;
      if (y < -lim) y = -lim;
      s4 = clamp_sample(y);
      return s4[OUT_W-1:0];
   endfunction

   task automatic push_sample(logic [SAMPLE_W-1:0] smp, logic [FC_W-1:0] fc,
                              logic [RES_W-1:0] res);
      drive_entry_type e;
      e.is_retune = 0; e.do_write = 0; e.isr = '0;
      e.txn.smp = smp; e.txn.fc = fc; e.txn.res = res;
      pending_q.push_back(e);
   endtask

   task automatic push_retune(bit wr, logic [ISR_W-1:0] isr);
      drive_entry_type e;
      e.is_retune = 1; e.do_write = wr; e.isr = isr; e.txn = '0;
      pending_q.push_back(e);
   endtask

   // Mostly musical samples and settings, with a share of full-range noise.
   task automatic push_random(int n);
      logic [SAMPLE_W-1:0] smp;
      logic [FC_W-1:0] fc;
      logic [RES_W-1:0] res;
      for (int i = 0; i < n; i++) begin
         smp = SAMPLE_W'($urandom);
         if ($urandom_range(3) != 0)
            smp = SAMPLE_W'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
         fc  = FC_W'(($urandom_range(3) == 0) ? $urandom : $urandom_range(20, 12000));
         res = RES_W'(($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 62000));
         push_sample(smp, fc, res);
      end
   endtask

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;
   end

   // Stimulus plan.
   initial begin
      logic [ISR_W-1:0] rates[5];
      rates = '{20'd22369, 20'd536871, 20'd0, 20'hFFFFF, 20'd89478};
      mismatches = 0; n_sent = 0; n_checked = 0; n_writes = 0; stim_done = 0;
      mdl_isr = ISR_RESET;
      s1 = 0; s2 = 0; s3 = 0; s4 = 0; u1 = 0; u2 = 0; u3 = 0; u4 = 0;
      // Directed: field extremes, cutoff clamps, heavy feedback, saturation.
      push_sample(24'h7FFFFF, 16'd0, 16'd0);
      push_sample(24'h800000, 16'd65535, 16'd65535);
      push_sample(24'h7FFFFF, 16'd65535, 16'hFFFF);
      push_sample(24'h7FFFFF, 16'd65535, 16'hFFFF);
      push_sample(24'h800000, 16'd65535, 16'hFFFF);
      push_sample(24'h000000, 16'd1, 16'h8000);
      push_sample(24'h040000, 16'd1000, 16'h4000);
      push_sample(24'hFC0000, 16'd22050, 16'hF000);
      push_sample(24'h555555, 16'h5555, 16'h5555);
      push_sample(24'hAAAAAA, 16'hAAAA, 16'hAAAA);
      push_sample(24'h000001, 16'd24000, 16'd0);
      push_sample(24'hFFFFFF, 16'd5, 16'd1);
      push_random(300);
      // Sweep the rate register, extremes included.
      foreach (rates[i]) begin
         push_retune(1, rates[i]);
         push_sample(24'h7FFFFF, 16'd65535, 16'hFFFF);
         push_sample(24'h800000, 16'd0, 16'hFFFF);
         push_random(250);
      end
      // Pause without a write so the sender waits for every result.
      push_retune(0, '0);
      push_random(50);
   end

   // Track acceptance at the rising edge for the driver.
   bit last_accept;
   int drain_cnt;
   always @(posedge clock) begin
      last_accept <= req_valid && req_ready;
      if (reset || filtered_q.size() != 0) drain_cnt <= 0;
      else if (drain_cnt < DRAIN_CYCLES) drain_cnt <= drain_cnt + 1;
   end

   // Driver: bursts with random gaps, falling-edge updates.
   int  burst_left, gap_left;
   bit  retune_wait;
   bit  wr_now;
   drive_entry_type cur;
   always @(negedge clock) begin
      wr_now = 1'b0;
      if (reset) begin
         req_valid <= 1'b0; req_sample_in <= '0; req_cutoff_hz <= '0;
         req_resonance <= '0; csr_wr_data <= '0;
         burst_left = 0; gap_left = 0; retune_wait = 0;
      end else if (req_valid && !last_accept) begin
         // hold until accepted
      end else if (retune_wait) begin
         req_valid <= 1'b0;
         if (filtered_q.size() == 0 && drain_cnt >= DRAIN_CYCLES) begin
            if (cur.do_write) begin
               wr_now = 1'b1; csr_wr_data <= cur.isr;
               mdl_isr = cur.isr; n_writes++;
            end
            retune_wait = 0;
         end
      end else if (gap_left > 0) begin
         req_valid <= 1'b0;
         gap_left--;
      end else if (pending_q.size() != 0) begin
         cur = pending_q.pop_front();
         if (cur.is_retune) begin
            req_valid <= 1'b0;
            retune_wait = 1;
         end else begin
            req_valid <= 1'b1;
            req_sample_in <= cur.txn.smp;
            req_cutoff_hz <= cur.txn.fc;
            req_resonance <= cur.txn.res;
            filtered_q.push_back(ladder_step(cur.txn));
            n_sent++;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
            end else begin
               burst_left--;
               if (burst_left == 0) gap_left = ($urandom_range(3) == 0) ? 0 :
                                               $urandom_range(1, 300);
            end
         end
      end else begin
         req_valid <= 1'b0;
         stim_done = 1;
      end
      csr_wr_en <= wr_now;
   end

   // Receiver stall pattern with one long hold-off.
   int  stall_mode, stall_cnt, long_hold;
   bit  long_done;
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0; stall_mode = 0; stall_cnt = 0; long_hold = 0; long_done = 0;
      end else if (!long_done && n_sent > 150) begin
         rsp_ready <= 1'b0;
         long_hold++;
         if (long_hold >= 3000) long_done = 1;
      end else begin
         if (stall_cnt == 0) begin
            stall_mode = $urandom_range(2);
            stall_cnt = $urandom_range(20, 400);
         end
         stall_cnt--;
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(1));
            default: rsp_ready <= ($urandom_range(7) == 0);
         endcase
      end
   end

   // Monitor and checker.
   logic signed [OUT_W-1:0] exp_out;
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (filtered_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected output transaction: sample_out=%0d", rsp_sample_out);
         end else begin
            exp_out = filtered_q.pop_front();
            n_checked++;
            if (rsp_sample_out !== exp_out) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("sample_out mismatch at output %0d: expected %0d, got %0d",
                           n_checked, exp_out, rsp_sample_out);
            end
         end
      end
   end

   // Watchdog and end of run.
   initial begin
      idle_cycles = 0;
      @(negedge reset);
      while (!(stim_done && filtered_q.size() == 0 && drain_cnt >= DRAIN_CYCLES)) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) break;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d outputs outstanding", filtered_q.size());
         $display("RESULT: ERROR");
      end else begin
         $display("Filtered %0d samples across %0d rate settings, %0d checked, %0d mismatches.",
                  n_sent, n_writes + 1, n_checked, mismatches);
         if (mismatches == 0) $display("RESULT: OK");
         else $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
